>>> hdl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent in this cycle implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

// Antecedent implies consequent in the same cycle.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

`endif

>>> hdl/tlts_pkg.sv
// Shared types, codes and constants of the traffic light controller.
package tlts_pkg;

  localparam int DUR_W = 7;
  localparam int MAX_DURATION_DEF = 99;

  localparam logic [1:0] MODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_RED    = 2'd1;
  localparam logic [1:0] MODE_YELLOW = 2'd2;
  localparam logic [1:0] MODE_GREEN  = 2'd3;

  localparam logic [1:0] PH_RG = 2'd0;  // A red, B green
  localparam logic [1:0] PH_RY = 2'd1;  // A red, B yellow
  localparam logic [1:0] PH_GR = 2'd2;  // A green, B red
  localparam logic [1:0] PH_YR = 2'd3;  // A yellow, B red

  localparam logic [3:0] BTN_MODE = 4'd0;
  localparam logic [3:0] BTN_INC  = 4'd1;
  localparam logic [3:0] BTN_SAVE = 4'd2;

  localparam logic REQ_TICK   = 1'b0;
  localparam logic REQ_BUTTON = 1'b1;

  localparam logic [2:0] LAMP_OFF    = 3'b000;
  localparam logic [2:0] LAMP_RED    = 3'b001;
  localparam logic [2:0] LAMP_YELLOW = 3'b010;
  localparam logic [2:0] LAMP_GREEN  = 3'b100;

  localparam logic [DUR_W-1:0] RST_COUNT  = 7'd5;
  localparam logic [DUR_W-1:0] RST_RED    = 7'd5;
  localparam logic [DUR_W-1:0] RST_GREEN  = 7'd3;
  localparam logic [DUR_W-1:0] RST_YELLOW = 7'd2;

  typedef struct packed {
    logic [1:0]       mode;
    logic [1:0]       phase;
    logic [DUR_W-1:0] count;
    logic [DUR_W-1:0] red_dur;
    logic [DUR_W-1:0] green_dur;
    logic [DUR_W-1:0] yellow_dur;
    logic [DUR_W-1:0] edit_red;
    logic [DUR_W-1:0] edit_green;
    logic [DUR_W-1:0] edit_yellow;
    logic             blink_on;
  } state_t;

  typedef struct packed {
    logic             reload_half;
    logic [2:0]       lamps_b;
    logic [2:0]       lamps_a;
    logic [DUR_W-1:0] countdown;
    logic [1:0]       phase;
    logic [1:0]       mode;
  } result_t;

endpackage

>>> hdl/tlts_core.sv
// Next-state and result logic for one tick or button beat.
module tlts_core #(
  parameter int MAX_DURATION = tlts_pkg::MAX_DURATION_DEF
) (
  input  tlts_pkg::state_t  st,
  input  logic              req_type,
  input  logic [3:0]        button,
  output tlts_pkg::state_t  st_next,
  output tlts_pkg::result_t res
);

  localparam logic [tlts_pkg::DUR_W:0]   MAX_W = (tlts_pkg::DUR_W+1)'(MAX_DURATION);
  localparam logic [tlts_pkg::DUR_W-1:0] MAX_N = tlts_pkg::DUR_W'(MAX_DURATION);

  always_comb begin
    tlts_pkg::state_t            n;
    logic [tlts_pkg::DUR_W-1:0]  sel;
    logic [tlts_pkg::DUR_W:0]    inc;
    logic [tlts_pkg::DUR_W:0]    sum;
    logic                        tick;
    logic [2:0]                  color;

    n     = st;
    sel   = '0;
    inc   = '0;
    sum   = '0;
    tick  = (req_type == tlts_pkg::REQ_TICK);
    color = tlts_pkg::LAMP_OFF;

    // button handling first
    if (req_type == tlts_pkg::REQ_BUTTON) begin
      case (button)
        tlts_pkg::BTN_MODE: begin
          if (n.mode == tlts_pkg::MODE_NORMAL) begin
            n.edit_red    = n.red_dur;
            n.edit_green  = n.green_dur;
            n.edit_yellow = n.yellow_dur;
          end
          n.mode = n.mode + 2'd1;
        end
        tlts_pkg::BTN_INC: begin
          unique case (n.mode)
            tlts_pkg::MODE_RED:    sel = n.edit_red;
            tlts_pkg::MODE_YELLOW: sel = n.edit_yellow;
            default:               sel = n.edit_green;
          endcase
          inc = {1'b0, sel} + 1'b1;
          if (n.mode != tlts_pkg::MODE_NORMAL) begin
            if (inc > MAX_W) begin
              // overflow reloads all edit copies
              n.edit_red    = n.red_dur;
              n.edit_green  = n.green_dur;
              n.edit_yellow = n.yellow_dur;
            end else begin
              unique case (n.mode)
                tlts_pkg::MODE_RED:    n.edit_red    = inc[tlts_pkg::DUR_W-1:0];
                tlts_pkg::MODE_YELLOW: n.edit_yellow = inc[tlts_pkg::DUR_W-1:0];
                default:               n.edit_green  = inc[tlts_pkg::DUR_W-1:0];
              endcase
            end
          end
        end
        tlts_pkg::BTN_SAVE: begin
          sum = {1'b0, n.edit_yellow} + {1'b0, n.edit_green};
          if (n.mode == tlts_pkg::MODE_RED || n.mode == tlts_pkg::MODE_YELLOW) begin
            n.red_dur    = n.edit_red;
            n.yellow_dur = n.edit_yellow;
            n.green_dur  = (n.edit_red >= n.edit_yellow) ?
                           (n.edit_red - n.edit_yellow) : '0;
            n.mode       = tlts_pkg::MODE_NORMAL;
          end else if (n.mode == tlts_pkg::MODE_GREEN) begin
            n.yellow_dur = n.edit_yellow;
            n.green_dur  = n.edit_green;
            n.red_dur    = (sum > MAX_W) ? MAX_N : sum[tlts_pkg::DUR_W-1:0];
            n.mode       = tlts_pkg::MODE_NORMAL;
          end
        end
        default: ;
      endcase
    end

    // display update
    if (n.mode == tlts_pkg::MODE_NORMAL) begin
      if (tick && n.count != '0) n.count = n.count - 1'b1;
      unique case (n.phase)
        tlts_pkg::PH_RG: begin
          if (n.count == n.yellow_dur || n.count == '0) n.phase = tlts_pkg::PH_RY;
        end
        tlts_pkg::PH_RY: begin
          if (n.count == '0) begin
            n.phase = tlts_pkg::PH_GR;
            n.count = n.green_dur;
          end
        end
        tlts_pkg::PH_GR: begin
          if (n.count == '0) begin
            n.phase = tlts_pkg::PH_YR;
            n.count = n.yellow_dur;
          end
        end
        default: begin
          if (n.count == '0) begin
            n.phase = tlts_pkg::PH_RG;
            n.count = n.red_dur;
          end
        end
      endcase
    end else begin
      unique case (n.mode)
        tlts_pkg::MODE_RED:    n.count = n.edit_red;
        tlts_pkg::MODE_YELLOW: n.count = n.edit_yellow;
        default:               n.count = n.edit_green;
      endcase
      if (tick) n.blink_on = ~n.blink_on;
    end

    st_next = n;

    res.mode        = n.mode;
    res.phase       = n.phase;
    res.countdown   = n.count;
    res.reload_half = (n.mode != tlts_pkg::MODE_NORMAL);
    if (n.mode == tlts_pkg::MODE_NORMAL) begin
      unique case (n.phase)
        tlts_pkg::PH_RG: begin
          res.lamps_a = tlts_pkg::LAMP_RED;
          res.lamps_b = tlts_pkg::LAMP_GREEN;
        end
        tlts_pkg::PH_RY: begin
          res.lamps_a = tlts_pkg::LAMP_RED;
          res.lamps_b = tlts_pkg::LAMP_YELLOW;
        end
        tlts_pkg::PH_GR: begin
          res.lamps_a = tlts_pkg::LAMP_GREEN;
          res.lamps_b = tlts_pkg::LAMP_RED;
        end
        default: begin
          res.lamps_a = tlts_pkg::LAMP_YELLOW;
          res.lamps_b = tlts_pkg::LAMP_RED;
        end
      endcase
    end else begin
      unique case (n.mode)
        tlts_pkg::MODE_RED:    color = tlts_pkg::LAMP_RED;
        tlts_pkg::MODE_YELLOW: color = tlts_pkg::LAMP_YELLOW;
        default:               color = tlts_pkg::LAMP_GREEN;
      endcase
      res.lamps_a = n.blink_on ? color : tlts_pkg::LAMP_OFF;
      res.lamps_b = res.lamps_a;
    end
  end

endmodule

>>> hdl/traffic_light_with_time_setting.sv
// Top level of the two-way traffic light controller with editable durations.
//
//   channel  dir  tdata / tuser (low bit first)                          beat
//   s_       in   tdata: button[3:0], pad[7:4]; tuser: req_type         event
//   m_       out  tdata: mode[1:0] phase[3:2] countdown[10:4]          status
//                 lamps_a[13:11] lamps_b[16:14] reload_half[17] pad
//
// One event beat per cycle while s_tready is high: the controller state updates
// in the cycle the beat is taken, and the status beat sits in the output register
// in the following cycle. Throughput is one beat per clock while not stalled.
// s_tready stays high while the output register is empty or being drained,
// so a stalled master holds exactly one pending status beat.
// rst (synchronous) restores the power-up durations 5/3/2 and phase A red/B green.
module traffic_light_with_time_setting #(
  parameter int MAX_DURATION = tlts_pkg::MAX_DURATION_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // button[3:0], zero pad[7:4]
  input  logic        s_tuser,   // req_type: 0 timer tick, 1 button press
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // mode, phase, countdown, lamps_a, lamps_b,
                                 // reload_half, zero pad[23:18]
);

  tlts_pkg::state_t  st;
  tlts_pkg::state_t  st_next;
  tlts_pkg::result_t res_next;
  tlts_pkg::result_t res;
  logic              take;

  // the output register frees up whenever its beat is taken downstream
  assign s_tready = !m_tvalid || m_tready;
  assign take     = s_tvalid && s_tready;

  tlts_core #(
    .MAX_DURATION(MAX_DURATION)
  ) u_core (
    .st       (st),
    .req_type (s_tuser),
    .button   (s_tdata[3:0]),
    .st_next  (st_next),
    .res      (res_next)
  );

  // controller state: only moves on an accepted event
  always_ff @(posedge clk) begin
    if (rst) begin
      st.mode        <= tlts_pkg::MODE_NORMAL;
      st.phase       <= tlts_pkg::PH_RG;
      st.count       <= tlts_pkg::RST_COUNT;
      st.red_dur     <= tlts_pkg::RST_RED;
      st.green_dur   <= tlts_pkg::RST_GREEN;
      st.yellow_dur  <= tlts_pkg::RST_YELLOW;
      st.edit_red    <= '0;
      st.edit_green  <= '0;
      st.edit_yellow <= '0;
      st.blink_on    <= 1'b0;
    end else if (take) begin
      st <= st_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res <= res_next;
    end
  end

  assign m_tdata = {6'd0, res};

endmodule

>>> hdl/tlts_checker.sv
// Port-level checker for the traffic light controller, bound to the top level.
`include "assert_macros.svh"

module tlts_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata
);

  logic [1:0] mode;
  logic [1:0] phase;
  logic [2:0] lamps_a;
  logic [2:0] lamps_b;
  logic       reload_half;
  logic       phase0;
  logic       rg_lamps;

  assign mode        = m_tdata[1:0];
  assign phase       = m_tdata[3:2];
  assign lamps_a     = m_tdata[13:11];
  assign lamps_b     = m_tdata[16:14];
  assign reload_half = m_tdata[17];
  assign phase0      = m_tvalid && mode == tlts_pkg::MODE_NORMAL && phase == tlts_pkg::PH_RG;
  assign rg_lamps    = lamps_a == tlts_pkg::LAMP_RED && lamps_b == tlts_pkg::LAMP_GREEN;

  // a held status beat stays offered
  `ASSERT_NEXT(a_hold_valid, clk, rst, m_tvalid && !m_tready, m_tvalid)

  // every accepted event yields a status beat in the next cycle
  `ASSERT_NEXT(a_event_result, clk, rst, s_tvalid && s_tready, m_tvalid)

  // half-second reload exactly in the edit modes
  `ASSERT_SAME(a_reload_mode, clk, rst, m_tvalid, reload_half == (mode != tlts_pkg::MODE_NORMAL))

  // normal mode, first phase: A red and B green
  `ASSERT_SAME(a_phase0_lamps, clk, rst, phase0, rg_lamps)

endmodule

bind traffic_light_with_time_setting tlts_checker u_tlts_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
